@@ design/four_neighbour_mean_stencil_core_macros.svh @@
// assertion macros shared by the checker
`ifndef FOUR_NEIGHBOUR_MEAN_STENCIL_CORE_MACROS_SVH
`define FOUR_NEIGHBOUR_MEAN_STENCIL_CORE_MACROS_SVH

// checked only outside reset
`define FNMS_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define FNMS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/fnms_pkg.sv @@
package fnms_pkg;

  localparam int DEF_MAX_WIDTH   = 1024;
  localparam int DEF_MAX_HEIGHT  = 1024;
  localparam int DEF_SAMPLE_BITS = 16;

  localparam int             DIM_W     = 11;
  localparam int             DIM_MAX   = (1 << DIM_W) - 1;
  localparam logic [DIM_W-1:0] DIM_RESET = 11'd1024;

  localparam int OUT_DEPTH = 8;

  typedef enum logic [0:0] {
    REG_GRID_HEIGHT = 1'b0,
    REG_GRID_WIDTH  = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic valid;
    logic produce;
    logic has_up;
    logic has_left;
    logic has_down;
    logic has_right;
    logic last;
  } cell_ctl_t;

endpackage

@@ design/fnms_line_mem.sv @@
module fnms_line_mem #(
  parameter int ADDR_W = 11,
  parameter int DATA_W = 16
) (
  input  logic              clk,
  input  logic              re,
  input  logic [ADDR_W-1:0] up_addr,
  input  logic [ADDR_W-1:0] nb_addr,
  output logic [DATA_W-1:0] up_data,
  output logic [DATA_W-1:0] nb_data,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata
);

  logic [DATA_W-1:0] mem [1 << ADDR_W];

  // read-first: the up word is read in the same cycle it is overwritten
  always_ff @(posedge clk) begin
    if (re) begin
      up_data <= mem[up_addr];
      nb_data <= mem[nb_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

@@ design/fnms_avg.sv @@
module fnms_avg #(
  parameter int SAMPLE_BITS = fnms_pkg::DEF_SAMPLE_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  fnms_pkg::cell_ctl_t           ctl,
  input  logic signed [SAMPLE_BITS-1:0] down,
  input  logic signed [SAMPLE_BITS-1:0] up_data,
  input  logic signed [SAMPLE_BITS-1:0] nb_data,
  output logic                          res_valid,
  output logic        [SAMPLE_BITS-1:0] res_average,
  output logic                          res_last
);

  localparam int SUM_W = SAMPLE_BITS + 2;
  localparam int MAG_W = SAMPLE_BITS + 2;
  localparam int K     = SAMPLE_BITS + 2;
  localparam logic [K-1:0] DIV3_MUL = K'(((64'd1 << K) + 64'd2) / 64'd3);

  typedef enum logic [1:0] {
    DIV_BY_2 = 2'd0,
    DIV_BY_3 = 2'd1,
    DIV_BY_4 = 2'd2
  } div_t;

  // previous row window: p1 is column c-1, p0 column c
  logic signed [SAMPLE_BITS-1:0] p0;
  logic signed [SAMPLE_BITS-1:0] p1;

  logic signed [SUM_W-1:0] t_up, t_left, t_down, t_right, sum;
  logic        [2:0]       count;
  div_t                    div;

  logic                    s2_valid;
  logic                    s2_last;
  logic signed [SUM_W-1:0] s2_sum;
  div_t                    s2_div;

  logic              s3_valid;
  logic              s3_last;
  logic              s3_neg;
  logic [MAG_W-1:0]  s3_abs;
  div_t              s3_div;

  logic [MAG_W+K-1:0]     prod;
  logic [SAMPLE_BITS-1:0] mag_next;

  logic                   s4_valid;
  logic                   s4_last;
  logic                   s4_neg;
  logic [SAMPLE_BITS-1:0] s4_mag;

  always_comb begin
    t_up    = ctl.has_up    ? SUM_W'(up_data) : '0;
    t_left  = ctl.has_left  ? SUM_W'(p1)      : '0;
    t_down  = ctl.has_down  ? SUM_W'(down)    : '0;
    t_right = ctl.has_right ? SUM_W'(nb_data) : '0;
    sum     = t_up + t_left + t_down + t_right;
    count   = 3'(ctl.has_up) + 3'(ctl.has_left) + 3'(ctl.has_down) + 3'(ctl.has_right);
    priority if (count == 3'd4) begin
      div = DIV_BY_4;
    end else if (count == 3'd3) begin
      div = DIV_BY_3;
    end else begin
      div = DIV_BY_2;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.valid) begin
      p1 <= p0;
      p0 <= nb_data;
    end
    s2_sum  <= sum;
    s2_div  <= div;
    s2_last <= ctl.last;
    s3_neg  <= s2_sum[SUM_W-1];
    s3_abs  <= s2_sum[SUM_W-1] ? MAG_W'(-s2_sum) : MAG_W'(s2_sum);
    s3_div  <= s2_div;
    s3_last <= s2_last;
    s4_mag  <= mag_next;
    s4_neg  <= s3_neg;
    s4_last <= s3_last;
  end

  always_comb begin
    prod = (MAG_W+K)'(s3_abs) * (MAG_W+K)'(DIV3_MUL);
    unique case (s3_div)
      DIV_BY_2: mag_next = SAMPLE_BITS'(s3_abs >> 1);
      DIV_BY_3: mag_next = prod[K +: SAMPLE_BITS];
      DIV_BY_4: mag_next = SAMPLE_BITS'(s3_abs >> 2);
      default:  mag_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else begin
      s2_valid <= ctl.valid & ctl.produce;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
    end
  end

  assign res_valid   = s4_valid;
  assign res_average = s4_neg ? -s4_mag : s4_mag;
  assign res_last    = s4_last;

endmodule

@@ design/fnms_fifo.sv @@
module fnms_fifo #(
  parameter int DATA_W = 17,
  parameter int DEPTH  = fnms_pkg::OUT_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  logic [DATA_W-1:0] wr_data,
  output logic              rd_valid,
  input  logic              rd_ready,
  output logic [DATA_W-1:0] rd_data
);

  localparam int PTR_W = $clog2(DEPTH);

  logic [DATA_W-1:0] buf_q [DEPTH];
  logic [PTR_W-1:0]  wptr;
  logic [PTR_W-1:0]  rptr;
  logic [PTR_W:0]    count;
  logic              rd_en;

  assign rd_valid = count != '0;
  assign rd_en    = rd_valid & rd_ready;
  assign rd_data  = buf_q[rptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      buf_q[wptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr_en) begin
        wptr <= (wptr == PTR_W'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (rd_en) begin
        rptr <= (rptr == PTR_W'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      count <= count + (PTR_W+1)'(wr_en) - (PTR_W+1)'(rd_en);
    end
  end

endmodule

@@ design/four_neighbour_mean_stencil_core.sv @@
// Four-neighbour mean over a raster grid: every cell gets the mean of the up, down, left and
// right neighbours it has (two at a corner, three on an edge, four inside), truncated toward
// zero. Samples stream in one word per clock with no bubbles; a cell comes out one row late,
// when the sample below it arrives, so after the frame the host sends a row of words of the
// effective width to flush the last row; their pad flag is ignored (pad words inside the frame
// are dropped). The two most recent rows sit in one synchronous line store (two banks by row
// parity) read at two ports and written at one per word; the left and right neighbours come
// from a short window fed by a one-word lookahead read. Up to eight results may be
// outstanding, after which s_tready drops until results are taken. A register write restarts
// the frame; dimensions below 2 or above the build limits are saturated. The store needs no
// clearing after reset.
module four_neighbour_mean_stencil_core #(
  parameter int MAX_WIDTH   = fnms_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT  = fnms_pkg::DEF_MAX_HEIGHT,
  parameter int SAMPLE_BITS = fnms_pkg::DEF_SAMPLE_BITS
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]       s_tdata,  // sample
  input  logic                                   s_tuser,  // pad
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]       m_tdata,  // average
  output logic                                   m_tlast,
  input  logic                                   cfg_we,
  input  logic [0:0]                             cfg_index,
  input  logic [fnms_pkg::DIM_W-1:0]             cfg_data
);

  localparam int TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int HMAX    = (MAX_HEIGHT < fnms_pkg::DIM_MAX) ? MAX_HEIGHT : fnms_pkg::DIM_MAX;
  localparam int WMAX    = (MAX_WIDTH < fnms_pkg::DIM_MAX) ? MAX_WIDTH : fnms_pkg::DIM_MAX;
  localparam int ROW_W   = $clog2(HMAX + 1);
  localparam int COL_W   = $clog2(WMAX);
  localparam int ADDR_W  = COL_W + 1;
  localparam int CRED_W  = $clog2(fnms_pkg::OUT_DEPTH + 1);

  logic [fnms_pkg::DIM_W-1:0] grid_height;
  logic [fnms_pkg::DIM_W-1:0] grid_width;
  logic [ROW_W-1:0]           h_eff;
  logic [COL_W:0]             w_eff;
  logic [COL_W-1:0]           col_max;

  logic [ROW_W-1:0] row;
  logic [COL_W-1:0] col;
  logic [CRED_W-1:0] credits;

  logic                          accept;
  logic                          eff;
  logic                          draining;
  logic                          col_end;
  logic signed [SAMPLE_BITS-1:0] sample;

  logic [ADDR_W-1:0] cur_addr;
  logic [ADDR_W-1:0] nb_addr;
  logic [SAMPLE_BITS-1:0] up_data;
  logic [SAMPLE_BITS-1:0] nb_data;

  fnms_pkg::cell_ctl_t           ctl_next;
  fnms_pkg::cell_ctl_t           ctl;
  logic signed [SAMPLE_BITS-1:0] down;

  logic                   res_valid;
  logic [SAMPLE_BITS-1:0] res_average;
  logic                   res_last;
  logic [SAMPLE_BITS:0]   out_word;
  logic                   out_take;

  // saturated dimensions
  always_comb begin
    priority if (grid_height < fnms_pkg::DIM_W'(2)) begin
      h_eff = ROW_W'(2);
    end else if (grid_height > fnms_pkg::DIM_W'(HMAX)) begin
      h_eff = ROW_W'(HMAX);
    end else begin
      h_eff = grid_height[ROW_W-1:0];
    end
    priority if (grid_width < fnms_pkg::DIM_W'(2)) begin
      w_eff = (COL_W+1)'(2);
    end else if (grid_width > fnms_pkg::DIM_W'(WMAX)) begin
      w_eff = (COL_W+1)'(WMAX);
    end else begin
      w_eff = grid_width[COL_W:0];
    end
    col_max = COL_W'(w_eff - 1'b1);
  end

  assign sample   = s_tdata[SAMPLE_BITS-1:0];
  assign s_tready = ~rst & (credits < CRED_W'(fnms_pkg::OUT_DEPTH));
  assign accept   = s_tvalid & s_tready;
  assign draining = row >= h_eff;
  assign col_end  = col == col_max;
  assign eff      = accept & (draining | ~s_tuser);

  // the neighbour port runs one column ahead in the previous row; at the row end it
  // prefetches column 0 of the current row for the next one
  assign cur_addr = {row[0], col};
  assign nb_addr  = col_end ? {row[0], COL_W'(0)} : {~row[0], col + 1'b1};

  always_comb begin
    ctl_next.valid     = eff;
    ctl_next.produce   = row != '0;
    ctl_next.has_up    = row > ROW_W'(1);
    ctl_next.has_left  = col != '0;
    ctl_next.has_down  = ~draining;
    ctl_next.has_right = ~col_end;
    ctl_next.last      = draining & col_end;
  end

  fnms_line_mem #(
    .ADDR_W (ADDR_W),
    .DATA_W (SAMPLE_BITS)
  ) u_mem (
    .clk     (clk),
    .re      (eff),
    .up_addr (cur_addr),
    .nb_addr (nb_addr),
    .up_data (up_data),
    .nb_data (nb_data),
    .we      (eff & ~draining),
    .waddr   (cur_addr),
    .wdata   (sample)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_height <= fnms_pkg::DIM_RESET;
      grid_width  <= fnms_pkg::DIM_RESET;
      row         <= '0;
      col         <= '0;
      ctl         <= '0;
    end else begin
      ctl <= ctl_next;
      if (cfg_we) begin
        unique case (fnms_pkg::reg_index_t'(cfg_index))
          fnms_pkg::REG_GRID_HEIGHT: grid_height <= cfg_data;
          fnms_pkg::REG_GRID_WIDTH:  grid_width  <= cfg_data;
        endcase
        row <= '0;
        col <= '0;
      end else if (eff) begin
        if (col_end) begin
          col <= '0;
          row <= draining ? '0 : row + 1'b1;
        end else begin
          col <= col + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (eff) begin
      down <= sample;
    end
  end

  fnms_avg #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_avg (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .down        (down),
    .up_data     (up_data),
    .nb_data     (nb_data),
    .res_valid   (res_valid),
    .res_average (res_average),
    .res_last    (res_last)
  );

  // results reserved at accept, released when taken
  assign out_take = m_tvalid & m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      credits <= '0;
    end else begin
      credits <= credits + CRED_W'(eff & ctl_next.produce) - CRED_W'(out_take);
    end
  end

  fnms_fifo #(
    .DATA_W (SAMPLE_BITS + 1),
    .DEPTH  (fnms_pkg::OUT_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (res_valid),
    .wr_data  ({res_last, res_average}),
    .rd_valid (m_tvalid),
    .rd_ready (m_tready),
    .rd_data  (out_word)
  );

  assign m_tdata = TDATA_W'(out_word[SAMPLE_BITS-1:0]);
  assign m_tlast = out_word[SAMPLE_BITS];

endmodule

@@ design/fnms_checker.sv @@
`include "four_neighbour_mean_stencil_core_macros.svh"

module fnms_checker #(
  parameter int TDATA_W = 16
) (
  input logic               clk,
  input logic               rst,
  input logic               s_tvalid,
  input logic               s_tready,
  input logic               m_tvalid,
  input logic               m_tready,
  input logic [TDATA_W-1:0] m_tdata,
  input logic               m_tlast
);

  // clean start: empty output, input open
  `FNMS_ASSERT_ALWAYS(a_reset_exit, clk, $fell(rst) |-> (s_tready && !m_tvalid), "bad state after reset")

  // a stalled word holds
  `FNMS_ASSERT(a_out_hold, clk, rst, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)), "output word changed while stalled")

  // input reopens only when a word leaves
  `FNMS_ASSERT(a_ready_reopen, clk, rst, (!s_tready && !(m_tvalid && m_tready)) |=> !s_tready, "ready rose with no word taken")

  // a blocked idle input implies an output word, in m_tvalid now or as sampled by $past
  `FNMS_ASSERT(a_blocked_has_output, clk, rst, (!s_tready && !s_tvalid) |-> m_tvalid || $past(m_tvalid), "input blocked with nothing to deliver")

endmodule

bind four_neighbour_mean_stencil_core fnms_checker #(
  .TDATA_W (TDATA_W)
) u_fnms_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

@@ dv/tb_four_neighbour_mean_stencil_core.sv @@
`timescale 1ns / 100ps

module tb_four_neighbour_mean_stencil_core;

  typedef enum int {
    SINK_OPEN,
    SINK_RANDOM,
    SINK_PATTERN
  } sink_mode_t;

  typedef struct {
    logic [15:0] mean;
    logic        last;
  } cell_mean_t;

  localparam int LINE_DEPTH = fnms_pkg::DEF_MAX_WIDTH;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 10;
  localparam int RANDOM_WORDS = 950;

  // small grid with extremes; the bottom right corner sums to -1, so truncation gives 0
  localparam logic [0:8][15:0] EDGE_GRID = {
    16'h7FFF, 16'h8000, 16'h7FFF,
    16'h8000, 16'hFFFB, 16'h8000,
    16'h0001, 16'h7FFF, 16'hFFFE
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;       // sample
  logic        s_tuser = 1'b0;     // pad
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;            // average
  logic        m_tlast;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = '0;
  logic [fnms_pkg::DIM_W-1:0] cfg_data = '0;

  // predictor state
  logic signed [15:0]         shadow_rows [0:2*LINE_DEPTH-1];
  logic [fnms_pkg::DIM_W-1:0] grid_rows = fnms_pkg::DIM_RESET;
  logic [fnms_pkg::DIM_W-1:0] grid_cols = fnms_pkg::DIM_RESET;
  int                 cur_row = 0;
  int                 cur_col = 0;
  cell_mean_t         expected_means [$];
  cell_mean_t         oldest_mean;

  int         words_taken = 0;
  int         mismatches = 0;
  int         burst_left = 0;
  bit         src_gaps = 1'b0;
  sink_mode_t sink_mode = SINK_OPEN;
  bit         hold_req = 1'b0;
  int         hold_left = 0;
  int         sink_tick = 0;

  four_neighbour_mean_stencil_core u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic int fit_dim(input logic [fnms_pkg::DIM_W-1:0] v, input int hi);
    if (v < 2) return 2;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int bank_addr(input int row, input int col);
    return (row % 2) * LINE_DEPTH + col;
  endfunction

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  // stencil predictor, run once per accepted input word
  function automatic void predict_cell_mean(input logic [15:0] smp, input logic pad);
    int h, w, r, c, cr, sum, cnt;
    bit drain;
    cell_mean_t pred;
    h = fit_dim(grid_rows, fnms_pkg::DEF_MAX_HEIGHT);
    w = fit_dim(grid_cols, fnms_pkg::DEF_MAX_WIDTH);
    r = cur_row;
    c = cur_col;
    drain = (r >= h);
    if (!drain && pad) return;
    words_taken++;
    if (r >= 1) begin
      cr = r - 1;
      sum = 0;
      cnt = 0;
      if (cr > 0) begin
        sum += shadow_rows[bank_addr(r, c)];
        cnt++;
      end
      if (c > 0) begin
        sum += shadow_rows[bank_addr(cr, c - 1)];
        cnt++;
      end
      if (cr < h - 1) begin
        sum += $signed(smp);
        cnt++;
      end
      if (c < w - 1) begin
        sum += shadow_rows[bank_addr(cr, c + 1)];
        cnt++;
      end
      pred.mean = 16'(sum / cnt);
      pred.last = (cr == h - 1) && (c == w - 1);
      expected_means.push_back(pred);
    end
    if (!drain) shadow_rows[bank_addr(r, c)] = smp;
    c++;
    if (c >= w) begin
      c = 0;
      r = drain ? 0 : r + 1;
    end
    cur_row = r;
    cur_col = c;
  endfunction

  task automatic send_word(input logic [15:0] smp, input logic pad);
    s_tvalid <= 1'b1;
    s_tdata  <= smp;
    s_tuser  <= pad;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_cell_mean(smp, pad);
    if (src_gaps) begin
      if (burst_left == 0) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        burst_left = $urandom_range(1, 12);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (expected_means.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // only called while idle; a write restarts the frame
  task automatic write_reg(input fnms_pkg::reg_index_t idx,
                           input logic [fnms_pkg::DIM_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == fnms_pkg::REG_GRID_HEIGHT) grid_rows = val;
    else grid_cols = val;
    cur_row = 0;
    cur_col = 0;
    @(posedge clk);
  endtask

  // one raster frame plus its drain row; stops after cut words when cut >= 0
  task automatic send_frame(input int cut);
    int h, w;
    h = fit_dim(grid_rows, fnms_pkg::DEF_MAX_HEIGHT);
    w = fit_dim(grid_cols, fnms_pkg::DEF_MAX_WIDTH);
    for (int i = 0; i < h * w; i++) begin
      if (i == cut) return;
      if ($urandom_range(0, 19) == 0) send_word(16'($urandom), 1'b1);
      send_word(rand_sample(), 1'b0);
    end
    for (int i = 0; i < w; i++) send_word(16'($urandom), $urandom_range(0, 4) != 0);
  endtask

  task automatic test_directed_edges();
    src_gaps = 1'b0;
    sink_mode = SINK_OPEN;
    wait_idle();
    // dimensions below 2 saturate to a 2x2 grid
    write_reg(fnms_pkg::REG_GRID_HEIGHT, 11'd0);
    write_reg(fnms_pkg::REG_GRID_WIDTH, 11'd1);
    send_word(16'hFFFF, 1'b0);
    send_word(16'h0000, 1'b0);
    send_word(16'h1234, 1'b1);
    send_word(16'h0000, 1'b0);
    send_word(16'h0002, 1'b0);
    send_word(16'h0000, 1'b1);
    send_word(16'h0000, 1'b1);
    // second frame back to back, drain words with and without the pad flag
    send_word(16'h7FFF, 1'b0);
    send_word(16'h8000, 1'b0);
    send_word(16'h8000, 1'b0);
    send_word(16'h7FFF, 1'b0);
    send_word(16'hFFFF, 1'b0);
    send_word(16'h0000, 1'b1);
    wait_idle();
    write_reg(fnms_pkg::REG_GRID_HEIGHT, 11'd3);
    write_reg(fnms_pkg::REG_GRID_WIDTH, 11'd3);
    for (int i = 0; i < 9; i++) send_word(EDGE_GRID[i], 1'b0);
    send_word(16'h5555, 1'b0);
    send_word(16'hAAAA, 1'b1);
    send_word(16'h0000, 1'b0);
  endtask

  task automatic test_register_abort();
    src_gaps = 1'b1;
    sink_mode = SINK_RANDOM;
    wait_idle();
    write_reg(fnms_pkg::REG_GRID_HEIGHT, 11'h7FF);
    write_reg(fnms_pkg::REG_GRID_WIDTH, 11'h7FF);
    repeat (40) send_word(rand_sample(), 1'b0);
    wait_idle();
    write_reg(fnms_pkg::REG_GRID_WIDTH, 11'd1024);
    write_reg(fnms_pkg::REG_GRID_HEIGHT, 11'd1024);
    repeat (12) send_word(rand_sample(), 1'b0);
    wait_idle();
    write_reg(fnms_pkg::REG_GRID_HEIGHT, 11'd4);
    write_reg(fnms_pkg::REG_GRID_WIDTH, 11'd3);
    send_frame(8);
    wait_idle();
    write_reg(fnms_pkg::REG_GRID_HEIGHT, 11'd4);
    send_frame(-1);
  endtask

  task automatic test_backpressure();
    wait_idle();
    write_reg(fnms_pkg::REG_GRID_HEIGHT, 11'd6);
    write_reg(fnms_pkg::REG_GRID_WIDTH, 11'd10);
    src_gaps = 1'b0;
    sink_mode = SINK_OPEN;
    hold_req = 1'b1;
    send_frame(-1);
  endtask

  task automatic test_random_frames();
    int start, h, w, cut;
    start = words_taken;
    while (words_taken - start < RANDOM_WORDS) begin
      src_gaps = $urandom_range(0, 2) != 0;
      sink_mode = sink_mode_t'($urandom_range(0, 2));
      if ($urandom_range(0, 2) == 0) begin
        wait_idle();
        h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 10);
        if ($urandom_range(0, 9) == 0) w = $urandom_range(0, 1);
        else if ($urandom_range(0, 4) == 0) w = $urandom_range(11, 48);
        else w = $urandom_range(2, 10);
        write_reg(fnms_pkg::REG_GRID_HEIGHT, fnms_pkg::DIM_W'(h));
        write_reg(fnms_pkg::REG_GRID_WIDTH, fnms_pkg::DIM_W'(w));
      end
      cut = -1;
      if ($urandom_range(0, 7) == 0)
        cut = $urandom_range(1, fit_dim(grid_rows, fnms_pkg::DEF_MAX_HEIGHT) *
                                fit_dim(grid_cols, fnms_pkg::DEF_MAX_WIDTH));
      send_frame(cut);
      if (cut >= 0) begin
        wait_idle();
        write_reg(fnms_pkg::REG_GRID_WIDTH, grid_cols);
      end
    end
  endtask

  // result receiver with its own stall pattern and long hold
  always @(posedge clk) begin
    sink_tick++;
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      case (sink_mode)
        SINK_RANDOM:  m_tready <= ($urandom_range(0, 3) != 0);
        SINK_PATTERN: m_tready <= ((sink_tick % 7) < 4);
        default:      m_tready <= 1'b1;
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_means.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected word, expected none, got average %h last %b",
                 $time, m_tdata, m_tlast);
      end else begin
        oldest_mean = expected_means.pop_front();
        if (m_tdata !== oldest_mean.mean) begin
          mismatches++;
          $display("%0t: average mismatch, expected %h, got %h",
                   $time, oldest_mean.mean, m_tdata);
        end
        if (m_tlast !== oldest_mean.last) begin
          mismatches++;
          $display("%0t: last mismatch, expected %b, got %b",
                   $time, oldest_mean.last, m_tlast);
        end
      end
    end
  end

  initial begin
    #5000000;
    $display("four_neighbour_mean_stencil_core verification failed");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_directed_edges();
    test_register_abort();
    test_backpressure();
    test_random_frames();
    wait_idle();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_means.size() == 0) begin
      $display("four_neighbour_mean_stencil_core verification clean");
    end else begin
      $display("four_neighbour_mean_stencil_core verification failed");
    end
    $finish;
  end

endmodule

@@ four_neighbour_mean_stencil_core.f @@
+incdir+design
design/fnms_pkg.sv
design/fnms_line_mem.sv
design/fnms_avg.sv
design/fnms_fifo.sv
design/four_neighbour_mean_stencil_core.sv
design/fnms_checker.sv
dv/tb_four_neighbour_mean_stencil_core.sv
